FILE: design/iougt_pkg.sv
// ----------------------------------------------------------------------------
// iougt_pkg
// Shared types and constants of the IoU-gated mutual nearest tracker.
// ----------------------------------------------------------------------------
package iougt_pkg;

    localparam int COORD_W = 12;
    localparam int TAG_W   = 32;
    localparam int ID_W    = 32;
    localparam int HIT_W   = 16;
    localparam int MISS_W  = 8;
    localparam int EV_W    = 3;
    localparam int DIST_W  = 29;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 8;

    // item opcodes
    localparam logic [1:0] OPC_DET     = 2'd0;
    localparam logic [1:0] OPC_DET_END = 2'd1;
    localparam logic [1:0] OPC_END     = 2'd2;
    localparam logic [1:0] OPC_CLEAR   = 2'd3;

    // result events
    localparam logic [EV_W-1:0] EV_MATCHED = 3'd0;
    localparam logic [EV_W-1:0] EV_MISSED  = 3'd1;
    localparam logic [EV_W-1:0] EV_NEW     = 3'd2;
    localparam logic [EV_W-1:0] EV_REMOVED = 3'd3;
    localparam logic [EV_W-1:0] EV_EMPTY   = 3'd4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_TARGET_LABEL = 8'd0;
    localparam logic [IDX_W-1:0] REG_HITS_ACCEPT  = 8'd1;
    localparam logic [IDX_W-1:0] REG_MISSES_DROP  = 8'd2;
    localparam logic [IDX_W-1:0] REG_IOU_THR      = 8'd3;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [7:0]               class_label;
        logic [COORD_W-1:0]       box_x;
        logic [COORD_W-1:0]       box_y;
        logic [COORD_W-1:0]       box_w;
        logic [COORD_W-1:0]       box_h;
        logic signed [TAG_W-1:0]  user_tag;
    } item_t;

    typedef struct packed {
        logic [EV_W-1:0]          event_res;
        logic [ID_W-1:0]          track_id;
        logic signed [TAG_W-1:0]  track_tag;
        logic [COORD_W-1:0]       out_x;
        logic [COORD_W-1:0]       out_y;
        logic [COORD_W-1:0]       out_w;
        logic [COORD_W-1:0]       out_h;
        logic [HIT_W-1:0]         hit_count;
        logic [MISS_W-1:0]        miss_count;
        logic                     acceptable;
        logic                     last_result;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } box_t;

    typedef struct packed {
        box_t             box;
        logic [TAG_W-1:0] tag;
    } det_ent_t;

    typedef struct packed {
        box_t              box;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
        logic [HIT_W-1:0]  hits;
        logic [MISS_W-1:0] misses;
    } trk_ent_t;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_INIT,
        OP_PRD,
        OP_PS1,
        OP_PS2,
        OP_PS3,
        OP_PS4,
        OP_PS5,
        OP_UCHK,
        OP_URD2,
        OP_UAPPLY,
        OP_CCHK,
        OP_CCOPY,
        OP_NCHK,
        OP_NWR,
        OP_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic pair_skip;
        logic j_last;
        logic i_last;
        logic i_done;
        logic dead_i;
        logic j_done;
        logic new_skip;
    } dp_status_t;

endpackage

FILE: design/iougt_ram.sv
// ----------------------------------------------------------------------------
// iougt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module iougt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/iougt_ctrl.sv
// ----------------------------------------------------------------------------
// iougt_ctrl
// Sequencer: steps the datapath through buffering, pairing, track update,
// compaction and track creation.
// ----------------------------------------------------------------------------
module iougt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           opcode,
    input  iougt_pkg::dp_status_t status,
    output iougt_pkg::dp_cmd_t    cmd,
    output logic                 busy
);
    import iougt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_PRD,
        S_PS1,
        S_PS2,
        S_PS3,
        S_PS4,
        S_PS5,
        S_UCHK,
        S_URD2,
        S_UAPPLY,
        S_CCHK,
        S_CCOPY,
        S_NCHK,
        S_NWR,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_ACCEPT;
                    if (opcode == OPC_DET_END || opcode == OPC_END)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = status.pair_skip ? S_UCHK : S_PRD;
            end
            S_PRD:
            begin
                cmd.op     = OP_PRD;
                state_next = S_PS1;
            end
            S_PS1:
            begin
                cmd.op     = OP_PS1;
                state_next = S_PS2;
            end
            S_PS2:
            begin
                cmd.op     = OP_PS2;
                state_next = S_PS3;
            end
            S_PS3:
            begin
                cmd.op     = OP_PS3;
                state_next = S_PS4;
            end
            S_PS4:
            begin
                cmd.op     = OP_PS4;
                state_next = S_PS5;
            end
            S_PS5:
            begin
                cmd.op     = OP_PS5;
                state_next = (status.j_last && status.i_last) ? S_UCHK : S_PRD;
            end
            S_UCHK:
            begin
                cmd.op     = OP_UCHK;
                state_next = status.i_done ? S_CCHK : S_URD2;
            end
            S_URD2:
            begin
                cmd.op     = OP_URD2;
                state_next = S_UAPPLY;
            end
            S_UAPPLY:
            begin
                cmd.op     = OP_UAPPLY;
                state_next = S_UCHK;
            end
            S_CCHK:
            begin
                cmd.op = OP_CCHK;
                if (status.i_done)
                begin
                    state_next = S_NCHK;
                end
                else if (status.dead_i)
                begin
                    state_next = S_CCOPY;
                end
            end
            S_CCOPY:
            begin
                cmd.op     = OP_CCOPY;
                state_next = S_CCHK;
            end
            S_NCHK:
            begin
                cmd.op = OP_NCHK;
                if (status.j_done)
                begin
                    state_next = S_FIN;
                end
                else if (!status.new_skip)
                begin
                    state_next = S_NWR;
                end
            end
            S_NWR:
            begin
                cmd.op     = OP_NWR;
                state_next = S_NCHK;
            end
            S_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: design/iougt_dp.sv
// ----------------------------------------------------------------------------
// iougt_dp
// Datapath: detection and track stores, pair distance and IoU gate pipeline,
// nearest-neighbour tables, table maintenance and result register.
// ----------------------------------------------------------------------------
module iougt_dp #(
    parameter int MAX_TRACKS     = 16,
    parameter int MAX_DETECTIONS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  iougt_pkg::dp_cmd_t                cmd,
    output iougt_pkg::dp_status_t             status,
    input  iougt_pkg::item_t                  item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [iougt_pkg::IDX_W-1:0]       cfg_index,
    input  logic [iougt_pkg::CFG_W-1:0]       cfg_data,
    output logic                              result_valid,
    output iougt_pkg::result_t                result
);
    import iougt_pkg::*;

    localparam int TIW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int TCW  = $clog2(MAX_TRACKS + 1);
    localparam int DIW  = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
    localparam int DCW  = $clog2(MAX_DETECTIONS + 1);
    localparam int N2OW = TIW + DIST_W;

    // configuration
    logic [CFG_W-1:0] target_label_reg, hits_acc_reg, miss_drop_reg, iou_thr_reg;

    // counters and flags
    logic [DCW-1:0]            det_count_reg, j_reg;
    logic [TCW-1:0]            trk_count_reg, cnt_reg, i_reg;
    logic [ID_W-1:0]           next_id_reg;
    logic [DIW-1:0]            m_reg;
    logic [MAX_TRACKS-1:0]     o2n_v_reg, dead_reg;
    logic [MAX_DETECTIONS-1:0] n2o_v_reg, used_reg;
    logic                      best_v_reg;
    logic [DIST_W-1:0]         best_d_reg;
    logic [DIW-1:0]            best_j_reg;

    // pair pipeline
    logic [12:0]           iw_reg, ih_reg;
    logic [13:0]           dx_reg, dy_reg;
    logic [25:0]           inter_reg;
    logic [23:0]           a1_reg, a2_reg;
    logic [27:0]           dx2_reg, dy2_reg;
    logic [24:0]           uni_reg;
    logic [DIST_W-1:0]     dsum_reg;
    logic [32:0]           thr_uni_reg;

    // result handling
    logic    pend_v_reg, result_valid_reg;
    result_t pend_reg, result_reg;

    // store ports
    det_ent_t        det_rd, det_wr;
    trk_ent_t        trk_rd, trk_wr;
    logic [N2OW-1:0] n2o_rd, n2o_wr;
    logic [DIW-1:0]  o2n_rd, o2n_wr;
    logic            det_we, trk_we, n2o_we, o2n_we;
    logic            det_re, trk_re, n2o_re, o2n_re;
    logic [DIW-1:0]  det_wa, det_ra;
    logic [TIW-1:0]  trk_wa, trk_ra;

    logic [TCW-1:0] cnt_dec;
    logic [DCW-1:0] det_dec;
    logic [TIW-1:0] i_a;
    logic [DIW-1:0] j_a;
    logic           accept_det;

    assign cnt_dec = cnt_reg - 1'b1;
    assign det_dec = det_count_reg - 1'b1;
    assign i_a     = i_reg[TIW-1:0];
    assign j_a     = j_reg[DIW-1:0];
    assign cfg_ready = 1'b1;

    assign accept_det = (item.opcode == OPC_DET || item.opcode == OPC_DET_END)
                        && item.class_label == target_label_reg
                        && det_count_reg < DCW'(MAX_DETECTIONS);

    // status to the sequencer
    assign status.pair_skip = (trk_count_reg == '0) || (det_count_reg == '0);
    assign status.j_last    = (j_reg == det_dec);
    assign status.i_last    = (i_reg == cnt_dec);
    assign status.i_done    = (i_reg >= cnt_reg);
    assign status.dead_i    = dead_reg[i_a];
    assign status.j_done    = (j_reg >= det_count_reg);
    assign status.new_skip  = used_reg[j_a] || (cnt_reg >= TCW'(MAX_TRACKS));

    // ---------------- stores ----------------
    iougt_ram #(.WIDTH($bits(det_ent_t)), .DEPTH(MAX_DETECTIONS)) u_det_ram (
        .clk(clk), .wr_en(det_we), .wr_addr(det_wa), .wr_data(det_wr),
        .rd_en(det_re), .rd_addr(det_ra), .rd_data(det_rd)
    );
    iougt_ram #(.WIDTH($bits(trk_ent_t)), .DEPTH(MAX_TRACKS)) u_trk_ram (
        .clk(clk), .wr_en(trk_we), .wr_addr(trk_wa), .wr_data(trk_wr),
        .rd_en(trk_re), .rd_addr(trk_ra), .rd_data(trk_rd)
    );
    iougt_ram #(.WIDTH(N2OW), .DEPTH(MAX_DETECTIONS)) u_n2o_ram (
        .clk(clk), .wr_en(n2o_we), .wr_addr(j_a), .wr_data(n2o_wr),
        .rd_en(n2o_re), .rd_addr(det_ra), .rd_data(n2o_rd)
    );
    iougt_ram #(.WIDTH(DIW), .DEPTH(MAX_TRACKS)) u_o2n_ram (
        .clk(clk), .wr_en(o2n_we), .wr_addr(i_a), .wr_data(o2n_wr),
        .rd_en(o2n_re), .rd_addr(i_a), .rd_data(o2n_rd)
    );

    // ---------------- pair gate and best updates ----------------
    logic              gated, upd_row, upd_col, nb_v;
    logic [DIW-1:0]    nb_j;
    logic [DIST_W-1:0] nb_d;

    assign gated   = {inter_reg, 8'b0} > {1'b0, thr_uni_reg};
    assign upd_row = gated && (!best_v_reg || dsum_reg < best_d_reg);
    assign upd_col = gated && (!n2o_v_reg[j_a] || dsum_reg < n2o_rd[DIST_W-1:0]);
    assign nb_v    = best_v_reg || gated;
    assign nb_j    = upd_row ? j_a : best_j_reg;
    assign nb_d    = upd_row ? dsum_reg : best_d_reg;

    // ---------------- track update ----------------
    logic              matched;
    logic [MISS_W-1:0] miss_inc;
    trk_ent_t          upd_ent;
    logic [EV_W-1:0]   upd_ev;

    assign matched  = o2n_v_reg[i_a] && n2o_v_reg[m_reg] && (n2o_rd[N2OW-1:DIST_W] == i_a);
    assign miss_inc = (trk_rd.misses != '1) ? trk_rd.misses + 1'b1 : trk_rd.misses;

    always_comb
    begin
        upd_ent = trk_rd;
        if (matched)
        begin
            upd_ent.box    = det_rd.box;
            upd_ent.hits   = (trk_rd.hits != '1) ? trk_rd.hits + 1'b1 : trk_rd.hits;
            upd_ent.misses = '0;
            upd_ev         = EV_MATCHED;
        end
        else
        begin
            upd_ent.misses = miss_inc;
            upd_ev         = (miss_inc >= miss_drop_reg) ? EV_REMOVED : EV_MISSED;
        end
    end

    // new track entry
    trk_ent_t new_ent;
    always_comb
    begin
        new_ent.box    = det_rd.box;
        new_ent.id     = next_id_reg;
        new_ent.tag    = det_rd.tag;
        new_ent.hits   = HIT_W'(1);
        new_ent.misses = '0;
    end

    // ---------------- store port control ----------------
    always_comb
    begin
        det_we = (cmd.op == OP_ACCEPT) && accept_det;
        det_wa = det_count_reg[DIW-1:0];
        det_wr = '{box: '{x: item.box_x, y: item.box_y, w: item.box_w, h: item.box_h},
                   tag: item.user_tag};
        det_re = (cmd.op == OP_PRD) || (cmd.op == OP_URD2) || (cmd.op == OP_NCHK);
        det_ra = (cmd.op == OP_URD2) ? o2n_rd : j_a;
        n2o_re = (cmd.op == OP_PRD) || (cmd.op == OP_URD2);
        n2o_we = (cmd.op == OP_PS5) && upd_col;
        n2o_wr = {i_a, dsum_reg};
        o2n_re = (cmd.op == OP_UCHK);
        o2n_we = (cmd.op == OP_PS5) && status.j_last;
        o2n_wr = nb_j;
        trk_re = (cmd.op == OP_PRD) || (cmd.op == OP_UCHK) || (cmd.op == OP_CCHK);
        trk_ra = (cmd.op == OP_CCHK) ? cnt_dec[TIW-1:0] : i_a;
        trk_we = 1'b0;
        trk_wa = i_a;
        trk_wr = trk_rd;
        case (cmd.op)
            OP_UAPPLY:
            begin
                trk_we = 1'b1;
                trk_wr = upd_ent;
            end
            OP_CCOPY:
            begin
                trk_we = 1'b1;
            end
            OP_NWR:
            begin
                trk_we = 1'b1;
                trk_wa = cnt_reg[TIW-1:0];
                trk_wr = new_ent;
            end
            default:
            begin
                trk_we = 1'b0;
            end
        endcase
    end

    // ---------------- result formation ----------------
    logic     emit_v;
    trk_ent_t emit_ent;
    result_t  emit_word, empty_word;

    always_comb
    begin
        emit_v   = (cmd.op == OP_UAPPLY) || (cmd.op == OP_NWR);
        emit_ent = (cmd.op == OP_NWR) ? new_ent : upd_ent;
        emit_word.event_res   = (cmd.op == OP_NWR) ? EV_NEW : upd_ev;
        emit_word.track_id    = emit_ent.id;
        emit_word.track_tag   = emit_ent.tag;
        emit_word.out_x       = emit_ent.box.x;
        emit_word.out_y       = emit_ent.box.y;
        emit_word.out_w       = emit_ent.box.w;
        emit_word.out_h       = emit_ent.box.h;
        emit_word.hit_count   = emit_ent.hits;
        emit_word.miss_count  = emit_ent.misses;
        emit_word.acceptable  = (emit_ent.hits >= HIT_W'(hits_acc_reg));
        emit_word.last_result = 1'b0;
        empty_word             = '0;
        empty_word.event_res   = EV_EMPTY;
        empty_word.last_result = 1'b1;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_label_reg <= 8'd0;
            hits_acc_reg     <= 8'd3;
            miss_drop_reg    <= 8'd5;
            iou_thr_reg      <= 8'd77;
            det_count_reg    <= '0;
            trk_count_reg    <= '0;
            cnt_reg          <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            next_id_reg      <= '0;
            o2n_v_reg        <= '0;
            n2o_v_reg        <= '0;
            used_reg         <= '0;
            dead_reg         <= '0;
            best_v_reg       <= 1'b0;
            pend_v_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TARGET_LABEL: target_label_reg <= cfg_data;
                    REG_HITS_ACCEPT:  hits_acc_reg     <= cfg_data;
                    REG_MISSES_DROP:  miss_drop_reg    <= cfg_data;
                    REG_IOU_THR:      iou_thr_reg      <= cfg_data;
                    default:          ;
                endcase
            end

            case (cmd.op)
                OP_ACCEPT:
                begin
                    if (item.opcode == OPC_CLEAR)
                    begin
                        det_count_reg <= '0;
                        trk_count_reg <= '0;
                        next_id_reg   <= '0;
                    end
                    else if (accept_det)
                    begin
                        det_count_reg <= det_count_reg + 1'b1;
                    end
                end
                OP_INIT:
                begin
                    i_reg      <= '0;
                    j_reg      <= '0;
                    cnt_reg    <= trk_count_reg;
                    o2n_v_reg  <= '0;
                    n2o_v_reg  <= '0;
                    used_reg   <= '0;
                    dead_reg   <= '0;
                    best_v_reg <= 1'b0;
                end
                OP_PS5:
                begin
                    if (upd_col)
                    begin
                        n2o_v_reg[j_a] <= 1'b1;
                    end
                    if (status.j_last)
                    begin
                        o2n_v_reg[i_a] <= nb_v;
                        best_v_reg     <= 1'b0;
                        j_reg          <= '0;
                        i_reg          <= status.i_last ? '0 : i_reg + 1'b1;
                    end
                    else
                    begin
                        best_v_reg <= nb_v;
                        j_reg      <= j_reg + 1'b1;
                    end
                end
                OP_UCHK:
                begin
                    if (status.i_done)
                    begin
                        i_reg <= '0;
                    end
                end
                OP_UAPPLY:
                begin
                    if (matched)
                    begin
                        used_reg[m_reg] <= 1'b1;
                    end
                    else if (upd_ev == EV_REMOVED)
                    begin
                        dead_reg[i_a] <= 1'b1;
                    end
                    i_reg <= i_reg + 1'b1;
                end
                OP_CCHK:
                begin
                    if (!status.i_done && !status.dead_i)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                OP_CCOPY:
                begin
                    dead_reg[i_a] <= dead_reg[cnt_dec[TIW-1:0]];
                    cnt_reg       <= cnt_dec;
                end
                OP_NCHK:
                begin
                    if (!status.j_done && status.new_skip)
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                OP_NWR:
                begin
                    cnt_reg     <= cnt_reg + 1'b1;
                    next_id_reg <= next_id_reg + 1'b1;
                    j_reg       <= j_reg + 1'b1;
                end
                OP_FIN:
                begin
                    trk_count_reg <= cnt_reg;
                    det_count_reg <= '0;
                end
                default:
                begin
                end
            endcase

            // result strobe: one word held back so the frame's last can be marked
            if (emit_v)
            begin
                result_valid_reg <= pend_v_reg;
                pend_v_reg       <= 1'b1;
            end
            else if (cmd.op == OP_FIN)
            begin
                result_valid_reg <= 1'b1;
                pend_v_reg       <= 1'b0;
            end
            else
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        // stage 1: overlap extents and centre offsets
        if (cmd.op == OP_PS1)
        begin
            iw_reg <= ov_len(det_rd.box.x, det_rd.box.w, trk_rd.box.x, trk_rd.box.w);
            ih_reg <= ov_len(det_rd.box.y, det_rd.box.h, trk_rd.box.y, trk_rd.box.h);
            dx_reg <= ctr_diff(det_rd.box.x, det_rd.box.w, trk_rd.box.x, trk_rd.box.w);
            dy_reg <= ctr_diff(det_rd.box.y, det_rd.box.h, trk_rd.box.y, trk_rd.box.h);
        end
        // stage 2: products
        if (cmd.op == OP_PS2)
        begin
            inter_reg <= iw_reg * ih_reg;
            a1_reg    <= det_rd.box.w * det_rd.box.h;
            a2_reg    <= trk_rd.box.w * trk_rd.box.h;
            dx2_reg   <= dx_reg * dx_reg;
            dy2_reg   <= dy_reg * dy_reg;
        end
        // stage 3: union and squared distance
        if (cmd.op == OP_PS3)
        begin
            uni_reg  <= 25'(a1_reg) + 25'(a2_reg) - inter_reg[24:0];
            dsum_reg <= DIST_W'(dx2_reg) + DIST_W'(dy2_reg);
        end
        // stage 4: threshold times union
        if (cmd.op == OP_PS4)
        begin
            thr_uni_reg <= iou_thr_reg * uni_reg;
        end
        if (cmd.op == OP_PS5)
        begin
            best_j_reg <= nb_j;
            best_d_reg <= nb_d;
        end
        if (cmd.op == OP_URD2)
        begin
            m_reg <= o2n_rd;
        end
        if (emit_v)
        begin
            result_reg <= pend_reg;
            pend_reg   <= emit_word;
        end
        else if (cmd.op == OP_FIN)
        begin
            result_reg             <= pend_v_reg ? pend_reg : empty_word;
            result_reg.last_result <= 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // length of the overlap of two intervals, zero when disjoint
    function automatic logic [12:0] ov_len(input logic [COORD_W-1:0] ap,
                                           input logic [COORD_W-1:0] al,
                                           input logic [COORD_W-1:0] bp,
                                           input logic [COORD_W-1:0] bl);
        logic [12:0] ae, be, lo, hi;
        ae = {1'b0, ap} + {1'b0, al};
        be = {1'b0, bp} + {1'b0, bl};
        lo = (ap > bp) ? {1'b0, ap} : {1'b0, bp};
        hi = (ae < be) ? ae : be;
        return (hi > lo) ? hi - lo : 13'd0;
    endfunction

    // absolute difference of doubled centres
    function automatic logic [13:0] ctr_diff(input logic [COORD_W-1:0] ap,
                                             input logic [COORD_W-1:0] al,
                                             input logic [COORD_W-1:0] bp,
                                             input logic [COORD_W-1:0] bl);
        logic [13:0] ca, cb;
        ca = {1'b0, ap, 1'b0} + {2'b0, al};
        cb = {1'b0, bp, 1'b0} + {2'b0, bl};
        return (ca > cb) ? ca - cb : cb - ca;
    endfunction

endmodule

FILE: design/iou_gated_mutual_nearest_tracker_top.sv
// ----------------------------------------------------------------------------
// iou_gated_mutual_nearest_tracker_top
// IoU-gated mutual nearest neighbour tracker for one object class.
// ----------------------------------------------------------------------------
// A detection word is taken while busy stays low, and the next word may
// follow at once. A word that ends a frame raises busy while the frame is
// resolved: pairing (each pair through the six-step read, gate and distance
// sequence), track update, compaction and new tracks, in that order.
// Results come one per strobe with no back-pressure: the receiver must take
// every cycle in which result_valid is high. The last result of a frame
// carries last_result; a frame without events gives one table-empty result.
// ----------------------------------------------------------------------------
module iou_gated_mutual_nearest_tracker_top #(
    parameter int MAX_TRACKS     = 16,
    parameter int MAX_DETECTIONS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  iougt_pkg::item_t               item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [iougt_pkg::IDX_W-1:0]    cfg_index,
    input  logic [iougt_pkg::CFG_W-1:0]    cfg_data,
    output logic                           result_valid,
    output iougt_pkg::result_t             result
);
    import iougt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    iougt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (item.opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    iougt_dp #(
        .MAX_TRACKS     (MAX_TRACKS),
        .MAX_DETECTIONS (MAX_DETECTIONS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
